FILE: rtl/coarse_time_hit_sorter_macros.svh
// Assertion helpers for the checker of the hit sorter.
`ifndef COARSE_TIME_HIT_SORTER_MACROS_SVH
`define COARSE_TIME_HIT_SORTER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// The condition must never be true.
`define CTS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

FILE: rtl/cths_pkg.sv
`timescale 1ns / 1ps

package cths_pkg;

    // Batch store size and coarse time scaling.
    localparam int BATCH_DEPTH  = 64;
    localparam int COARSE_SHIFT = 2;

    localparam int TIME_W    = 48;
    localparam int PAYLOAD_W = 64;
    localparam int IDX_W     = $clog2(BATCH_DEPTH);
    localparam int CNT_W     = $clog2(BATCH_DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BATCH_DEPTH);

    // One incoming hit beat.
    typedef struct packed {
        logic [TIME_W-1:0]    hit_time;
        logic [PAYLOAD_W-1:0] hit_payload;
        logic                 batch_end;
    } hit_in_t;

    // One sorted hit beat.
    typedef struct packed {
        logic [TIME_W-1:0]    sorted_time;
        logic [PAYLOAD_W-1:0] sorted_payload;
        logic                 last_out;
    } hit_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_hit;
        logic start_scan;
        logic shift;
        logic place;
        logic emit_start;
        logic out_load;
        logic out_next;
        logic clear_fill;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero;
        logic key_greater;
        logic pos_one;
        logic close_batch;
        logic out_fire;
        logic is_last;
    } dp_stat_t;

endpackage

FILE: rtl/coarse_time_hit_sorter.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Beat
// hit       in         hit_valid / hit_ready       hit_in_t (time, payload, batch_end)
// sorted    out        sorted_valid / sorted_ready hit_out_t (time, payload, last_out)
//
// A hit is taken in idle, then each stored hit with a larger coarse time is moved up one
// slot, one at a time through the single read port of the hit store, and then placed.
// Closing a batch emits its hits in order, one store read per beat.
// Reset clears the counters, the output valid flag and state; the store needs no clearing pass.
// While a batch is emitted, no hit is accepted; a stalled sorted beat holds its value.

module coarse_time_hit_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hit_valid,
    output logic               hit_ready,
    input  cths_pkg::hit_in_t  hit,
    output logic               sorted_valid,
    input  logic               sorted_ready,
    output cths_pkg::hit_out_t sorted
);
    import cths_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    cths_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hit store, counters and output register.
    cths_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .hit          (hit),
        .cmd          (cmd),
        .stat         (stat),
        .sorted_ready (sorted_ready),
        .sorted_valid (sorted_valid),
        .sorted       (sorted)
    );

endmodule

FILE: rtl/cths_dp.sv
`timescale 1ns / 1ps

module cths_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  cths_pkg::hit_in_t  hit,
    input  cths_pkg::dp_cmd_t  cmd,
    output cths_pkg::dp_stat_t stat,
    input  logic               sorted_ready,
    output logic               sorted_valid,
    output cths_pkg::hit_out_t sorted
);
    import cths_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]    t;
        logic [PAYLOAD_W-1:0] p;
    } entry_t;

    entry_t mem [BATCH_DEPTH];

    hit_in_t           hold_reg;
    entry_t            rd_data_reg;
    hit_out_t          out_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  emit_idx_reg, emit_idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    entry_t            wr_data;
    logic              out_fire;
    logic              is_last;

    assign out_fire = out_valid_reg && sorted_ready;
    assign is_last  = CNT_W'(emit_idx_reg) == CNT_W'(fill_reg - 1'b1);

    // Memory port selection.
    always_comb
    begin
        if (cmd.start_scan)
        begin
            rd_addr = IDX_W'(fill_reg - 1'b1);
        end
        else if (cmd.shift)
        begin
            rd_addr = pos_reg - IDX_W'(2);
        end
        else if (cmd.emit_start)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = emit_idx_reg + 1'b1;
        end
    end

    assign rd_en   = cmd.start_scan | cmd.shift | cmd.emit_start | cmd.out_next;
    assign wr_en   = cmd.shift | cmd.place;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift ? rd_data_reg : entry_t'{hold_reg.hit_time, hold_reg.hit_payload};

    // Hit store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Counter next values.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.load_hit)
        begin
            pos_next = IDX_W'(fill_reg);
        end
        else if (cmd.shift)
        begin
            pos_next = pos_reg - 1'b1;
        end

        fill_next = fill_reg;
        if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        else if (cmd.place)
        begin
            fill_next = fill_reg + 1'b1;
        end

        emit_idx_next = emit_idx_reg;
        if (cmd.emit_start)
        begin
            emit_idx_next = '0;
        end
        else if (cmd.out_next)
        begin
            emit_idx_next = emit_idx_reg + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            emit_idx_reg <= emit_idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the held hit and the output beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load_hit)
        begin
            hold_reg <= hit;
        end
        if (cmd.out_load)
        begin
            out_reg <= hit_out_t'{rd_data_reg.t, rd_data_reg.p, is_last};
        end
    end

    // Status back to the controller.
    always_comb
    begin
        stat.fill_zero   = fill_reg == '0;
        stat.key_greater = (rd_data_reg.t >> COARSE_SHIFT) > (hold_reg.hit_time >> COARSE_SHIFT);
        stat.pos_one     = pos_reg == IDX_W'(1);
        stat.close_batch = hold_reg.batch_end || (CNT_W'(fill_reg + 1'b1) == FULL_COUNT);
        stat.out_fire    = out_fire;
        stat.is_last     = out_reg.last_out;
    end

    assign sorted_valid = out_valid_reg;
    assign sorted       = out_reg;

endmodule

FILE: rtl/cths_ctrl.sv
`timescale 1ns / 1ps

module cths_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hit_valid,
    output logic               hit_ready,
    input  cths_pkg::dp_stat_t stat,
    output cths_pkg::dp_cmd_t  cmd
);
    import cths_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_PLACE = 6'b000100,
        S_ERD   = 6'b001000,
        S_ELOAD = 6'b010000,
        S_EWAIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign hit_ready = state_reg == S_IDLE;

    // Sequencer for insertion and emission.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (hit_valid)
                begin
                    cmd.load_hit = 1'b1;
                    if (stat.fill_zero)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Move entries with a larger coarse time up by one slot.
                if (stat.key_greater)
                begin
                    cmd.shift = 1'b1;
                    if (stat.pos_one)
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = stat.close_batch ? S_ERD : S_IDLE;
            end
            S_ERD:
            begin
                cmd.emit_start = 1'b1;
                state_next     = S_ELOAD;
            end
            S_ELOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (stat.out_fire)
                begin
                    if (stat.is_last)
                    begin
                        cmd.clear_fill = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_ELOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/cths_checker.sv
`timescale 1ns / 1ps
`include "coarse_time_hit_sorter_macros.svh"

module cths_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               hit_valid,
    input logic               hit_ready,
    input logic               sorted_valid,
    input logic               sorted_ready,
    input cths_pkg::hit_out_t sorted
);
    import cths_pkg::*;

    logic hit_fire;
    logic last_fire;
    logic sorted_stall;

    assign hit_fire     = hit_valid && hit_ready;
    assign last_fire    = sorted_valid && sorted_ready && sorted.last_out;
    assign sorted_stall = sorted_valid && !sorted_ready;

    // A stalled sorted beat keeps its value.
    `CTS_ASSERT_NEXT(a_sorted_hold, clk, rst_n, sorted_stall, sorted_valid && $stable(sorted))
    // Hits are never taken while a batch is being emitted.
    `CTS_ASSERT_NEVER(a_no_overlap, clk, rst_n, hit_ready && sorted_valid)
    // Every accepted hit leaves the block busy in the following cycle.
    `CTS_ASSERT_NEXT(a_busy_after_hit, clk, rst_n, hit_fire, !hit_ready)
    // The last sorted beat returns the block to accepting hits.
    `CTS_ASSERT_NEXT(a_last_ends, clk, rst_n, last_fire, !sorted_valid && hit_ready)

endmodule

bind coarse_time_hit_sorter cths_checker u_checker (.*);
